@@ hdl/via_pkg.sv @@
// Shared types and constants for the 6522 VIA register file.
// Holds the register map, command codes, IFR flag masks and item payloads.
// No dependencies.
`timescale 1ns / 1ps

package via_pkg;

    // Bus commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;

    // Register map
    localparam logic [3:0] ADDR_ORB    = 4'd0;
    localparam logic [3:0] ADDR_ORA    = 4'd1;
    localparam logic [3:0] ADDR_DDRB   = 4'd2;
    localparam logic [3:0] ADDR_DDRA   = 4'd3;
    localparam logic [3:0] ADDR_T1CL   = 4'd4;
    localparam logic [3:0] ADDR_T1CH   = 4'd5;
    localparam logic [3:0] ADDR_T1LL   = 4'd6;
    localparam logic [3:0] ADDR_T1LH   = 4'd7;
    localparam logic [3:0] ADDR_T2CL   = 4'd8;
    localparam logic [3:0] ADDR_T2CH   = 4'd9;
    localparam logic [3:0] ADDR_SR     = 4'd10;
    localparam logic [3:0] ADDR_ACR    = 4'd11;
    localparam logic [3:0] ADDR_PCR    = 4'd12;
    localparam logic [3:0] ADDR_IFR    = 4'd13;
    localparam logic [3:0] ADDR_IER    = 4'd14;
    localparam logic [3:0] ADDR_ORA_NH = 4'd15;

    // IFR bits
    localparam logic [7:0] FLAG_CA2 = 8'h01;
    localparam logic [7:0] FLAG_CA1 = 8'h02;
    localparam logic [7:0] FLAG_CB2 = 8'h08;
    localparam logic [7:0] FLAG_CB1 = 8'h10;
    localparam logic [7:0] FLAG_T2  = 8'h20;
    localparam logic [7:0] FLAG_T1  = 8'h40;
    localparam logic [7:0] FLAG_ANY = 8'h80;

    // PCR control field codes for independent CA2/CB2 interrupt mode
    localparam logic [2:0] PCR_IND_NEG = 3'b001;
    localparam logic [2:0] PCR_IND_POS = 3'b011;

    // Reset values
    localparam logic [7:0]  DDRB_RESET  = 8'hff;
    localparam logic [15:0] COUNT_RESET = 16'hffff;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] address;
        logic [7:0] write_data;
        logic [6:0] raise_flags;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_pulse;
        logic        unsupported_access;
        logic [7:0]  port_b_value;
        logic [7:0]  port_a_value;
        logic [15:0] timer1_value;
        logic [15:0] timer2_value;
        logic        timer2_irq_armed;
        logic        timer1_free_run;
        logic        timer1_drives_pb7;
        logic        timer2_counts_pulses;
    } rsp_t;

endpackage

@@ hdl/via_stream_if.sv @@
// Valid/ready channel carrying one item per handshake.
// Payload type is a parameter; depends on nothing else.
`timescale 1ns / 1ps

interface via_stream_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/via_6522_register_file_unit.sv @@
// Channel   Dir  Payload         Handshake
// request   in   via_pkg::req_t  valid/ready, item taken when both high
// result    out  via_pkg::rsp_t  valid/ready, item taken when both high
//
// One item per cycle sustained unless the result stalls. Path: input register,
// then the register-file update into the result register.
// Register state changes when an item passes from the input register into
// the result register. Reset (rst_n low) empties both pipeline registers and
// loads the VIA reset values. A stalled result holds; new items are still
// taken while the input register can move forward.
// Depends on via_pkg, via_stream_if, via_pipe_reg and via_reg_core.
`timescale 1ns / 1ps

module via_6522_register_file_unit (
    input  logic         clk,
    input  logic         rst_n,
    via_stream_if.sink   request,
    via_stream_if.source result
);

    via_stream_if #(.data_t(via_pkg::req_t)) req_q ();
    via_stream_if #(.data_t(via_pkg::rsp_t)) rsp_d ();

    // Input register
    via_pipe_reg #(.data_t(via_pkg::req_t)) u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (request),
        .down  (req_q)
    );

    // Register file update
    via_reg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (req_q),
        .down  (rsp_d)
    );

    // Result register
    via_pipe_reg #(.data_t(via_pkg::rsp_t)) u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (rsp_d),
        .down  (result)
    );

endmodule

@@ hdl/via_pipe_reg.sv @@
// Full-rate pipeline register between two valid/ready channels.
// Depends on via_stream_if.
`timescale 1ns / 1ps

module via_pipe_reg #(
    parameter type data_t = logic
) (
    input  logic         clk,
    input  logic         rst_n,
    via_stream_if.sink   up,
    via_stream_if.source down
);

    logic  valid_reg;
    data_t data_reg;

    // Take a new item when empty or when the held one leaves in the same cycle
    assign up.ready   = !valid_reg || down.ready;
    assign down.valid = valid_reg;
    assign down.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.valid && up.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (down.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            data_reg <= up.data;
        end
    end

endmodule

@@ hdl/via_reg_core.sv @@
// VIA register state and per-access update logic.
// Depends on via_pkg and via_stream_if.
`timescale 1ns / 1ps

module via_reg_core (
    input  logic         clk,
    input  logic         rst_n,
    via_stream_if.sink   up,
    via_stream_if.source down
);

    logic [7:0]  out_b_reg, out_b_next;
    logic [7:0]  out_a_reg, out_a_next;
    logic [7:0]  out_a_nh_reg, out_a_nh_next;
    logic [7:0]  dir_b_reg, dir_b_next;
    logic [7:0]  dir_a_reg, dir_a_next;
    logic [15:0] t1_latch_reg, t1_latch_next;
    logic [15:0] t1_count_reg, t1_count_next;
    logic [7:0]  t2_latch_low_reg, t2_latch_low_next;
    logic [15:0] t2_loaded_reg, t2_loaded_next;
    logic [15:0] t2_count_reg, t2_count_next;
    logic [7:0]  acr_reg, acr_next;
    logic [7:0]  pcr_reg, pcr_next;
    logic [6:0]  ier_reg, ier_next;
    logic [7:0]  ifr_reg, ifr_next;
    logic        t2_armed_reg, t2_armed_next;

    via_pkg::req_t req;
    logic          fire;
    logic [7:0]    rd;
    logic          irq;
    logic          unsup;
    logic          clr_en;
    logic [7:0]    clr_mask;
    logic [7:0]    pb_mask;
    logic [7:0]    pa_mask;
    logic [6:0]    kept;

    // Pass-through handshake; state commits when the item moves on
    assign req        = up.data;
    assign fire       = up.valid && down.ready;
    assign up.ready   = down.ready;
    assign down.valid = up.valid;

    // Port flag masks: CB2/CA2 survive in independent mode
    always_comb
    begin
        pb_mask = via_pkg::FLAG_CB1;
        if (pcr_reg[7:5] != via_pkg::PCR_IND_NEG && pcr_reg[7:5] != via_pkg::PCR_IND_POS)
        begin
            pb_mask = pb_mask | via_pkg::FLAG_CB2;
        end
        pa_mask = via_pkg::FLAG_CA1;
        if (pcr_reg[3:1] != via_pkg::PCR_IND_NEG && pcr_reg[3:1] != via_pkg::PCR_IND_POS)
        begin
            pa_mask = pa_mask | via_pkg::FLAG_CA2;
        end
    end

    // Access decode and next state
    always_comb
    begin
        out_b_next        = out_b_reg;
        out_a_next        = out_a_reg;
        out_a_nh_next     = out_a_nh_reg;
        dir_b_next        = dir_b_reg;
        dir_a_next        = dir_a_reg;
        t1_latch_next     = t1_latch_reg;
        t1_count_next     = t1_count_reg;
        t2_latch_low_next = t2_latch_low_reg;
        t2_loaded_next    = t2_loaded_reg;
        t2_count_next     = t2_count_reg;
        acr_next          = acr_reg;
        pcr_next          = pcr_reg;
        ier_next          = ier_reg;
        ifr_next          = ifr_reg;
        t2_armed_next     = t2_armed_reg;
        rd                = 8'h00;
        irq               = 1'b0;
        unsup             = 1'b0;
        clr_en            = 1'b0;
        clr_mask          = 8'h00;
        kept              = 7'h00;

        unique case (req.command)
            via_pkg::CMD_READ:
            begin
                unique case (req.address)
                    via_pkg::ADDR_ORB:
                    begin
                        clr_en   = 1'b1;
                        clr_mask = pb_mask;
                        rd       = out_b_reg;
                    end
                    via_pkg::ADDR_ORA:
                    begin
                        clr_en   = 1'b1;
                        clr_mask = pa_mask;
                        rd       = out_a_reg;
                    end
                    via_pkg::ADDR_DDRB: rd = dir_b_reg;
                    via_pkg::ADDR_DDRA: rd = dir_a_reg;
                    via_pkg::ADDR_T1CL:
                    begin
                        clr_en   = 1'b1;
                        clr_mask = via_pkg::FLAG_T1;
                        rd       = t1_count_reg[7:0];
                    end
                    via_pkg::ADDR_T1CH: rd = t1_count_reg[15:8];
                    via_pkg::ADDR_T1LL: rd = t1_latch_reg[7:0];
                    via_pkg::ADDR_T1LH: rd = t1_latch_reg[15:8];
                    via_pkg::ADDR_T2CL:
                    begin
                        t2_armed_next = 1'b1;
                        rd            = t2_loaded_reg[7:0];
                    end
                    via_pkg::ADDR_T2CH: rd = t2_loaded_reg[15:8];
                    via_pkg::ADDR_SR:   unsup = 1'b1;
                    via_pkg::ADDR_ACR:  rd = acr_reg;
                    via_pkg::ADDR_PCR:  rd = pcr_reg;
                    via_pkg::ADDR_IFR:  rd = ifr_reg;
                    via_pkg::ADDR_IER:  rd = {1'b1, ier_reg};
                    via_pkg::ADDR_ORA_NH: rd = out_a_nh_reg;
                    default: rd = 8'h00;
                endcase
            end
            via_pkg::CMD_WRITE:
            begin
                unique case (req.address)
                    via_pkg::ADDR_ORB:
                    begin
                        out_b_next = (out_b_reg & ~dir_b_reg) | (req.write_data & dir_b_reg);
                        clr_en     = 1'b1;
                        clr_mask   = pb_mask;
                    end
                    via_pkg::ADDR_ORA:
                    begin
                        out_a_next = (out_a_reg & ~dir_a_reg) | (req.write_data & dir_a_reg);
                        clr_en     = 1'b1;
                        clr_mask   = pa_mask;
                    end
                    via_pkg::ADDR_DDRB: dir_b_next = req.write_data;
                    via_pkg::ADDR_DDRA: dir_a_next = req.write_data;
                    via_pkg::ADDR_T1CL, via_pkg::ADDR_T1LL:
                        t1_latch_next = {t1_latch_reg[15:8], req.write_data};
                    via_pkg::ADDR_T1LH:
                        t1_latch_next = {req.write_data, t1_latch_reg[7:0]};
                    via_pkg::ADDR_T1CH:
                    begin
                        // Load counter from the full latch and drop PB7 when it is an output
                        t1_latch_next = {req.write_data, t1_latch_reg[7:0]};
                        t1_count_next = {req.write_data, t1_latch_reg[7:0]};
                        out_b_next    = out_b_reg & ~(dir_b_reg & via_pkg::FLAG_ANY);
                        clr_en        = 1'b1;
                        clr_mask      = via_pkg::FLAG_T1 | pb_mask;
                    end
                    via_pkg::ADDR_T2CL: t2_latch_low_next = req.write_data;
                    via_pkg::ADDR_T2CH:
                    begin
                        t2_loaded_next = {req.write_data, t2_latch_low_reg};
                        t2_count_next  = {req.write_data, t2_latch_low_reg};
                        t2_armed_next  = 1'b1;
                        clr_en         = 1'b1;
                        clr_mask       = via_pkg::FLAG_T2;
                    end
                    via_pkg::ADDR_SR:  unsup = 1'b1;
                    via_pkg::ADDR_ACR: acr_next = req.write_data;
                    via_pkg::ADDR_PCR: pcr_next = req.write_data;
                    via_pkg::ADDR_IFR:
                    begin
                        clr_en   = 1'b1;
                        clr_mask = req.write_data;
                    end
                    via_pkg::ADDR_IER:
                    begin
                        // Bit 7 selects set or clear of the given enables
                        if (req.write_data[7])
                        begin
                            ier_next = ier_reg | req.write_data[6:0];
                        end
                        else
                        begin
                            ier_next = ier_reg & ~req.write_data[6:0];
                        end
                        irq = |(ier_next & ifr_reg[6:0]);
                        ifr_next = {ifr_reg[7] | irq, ifr_reg[6:0]};
                    end
                    via_pkg::ADDR_ORA_NH:
                        out_a_nh_next = (out_a_nh_reg & ~dir_a_reg) | (req.write_data & dir_a_reg);
                    default: unsup = 1'b0;
                endcase
            end
            via_pkg::CMD_RAISE:
            begin
                irq      = |(ier_reg & req.raise_flags);
                ifr_next = {ifr_reg[7] | irq, ifr_reg[6:0] | req.raise_flags};
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase

        // Flag clear recomputes the summary bit from what is left
        if (clr_en)
        begin
            kept     = ifr_reg[6:0] & ~clr_mask[6:0];
            ifr_next = {|(kept & ier_reg), kept};
        end
    end

    // Result item reflects state after the access
    always_comb
    begin
        down.data.read_data            = rd;
        down.data.irq_pulse            = irq;
        down.data.unsupported_access   = unsup;
        down.data.port_b_value         = out_b_next;
        down.data.port_a_value         = out_a_next;
        down.data.timer1_value         = t1_count_next;
        down.data.timer2_value         = t2_count_next;
        down.data.timer2_irq_armed     = t2_armed_next;
        down.data.timer1_free_run      = acr_next[6];
        down.data.timer1_drives_pb7    = acr_next[7];
        down.data.timer2_counts_pulses = acr_next[5];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_b_reg        <= 8'h00;
            out_a_reg        <= 8'h00;
            out_a_nh_reg     <= 8'h00;
            dir_b_reg        <= via_pkg::DDRB_RESET;
            dir_a_reg        <= 8'h00;
            t1_latch_reg     <= 16'h0000;
            t1_count_reg     <= via_pkg::COUNT_RESET;
            t2_latch_low_reg <= 8'h00;
            t2_loaded_reg    <= 16'h0000;
            t2_count_reg     <= via_pkg::COUNT_RESET;
            acr_reg          <= 8'h00;
            pcr_reg          <= 8'h00;
            ier_reg          <= 7'h00;
            ifr_reg          <= 8'h00;
            t2_armed_reg     <= 1'b0;
        end
        else if (fire)
        begin
            out_b_reg        <= out_b_next;
            out_a_reg        <= out_a_next;
            out_a_nh_reg     <= out_a_nh_next;
            dir_b_reg        <= dir_b_next;
            dir_a_reg        <= dir_a_next;
            t1_latch_reg     <= t1_latch_next;
            t1_count_reg     <= t1_count_next;
            t2_latch_low_reg <= t2_latch_low_next;
            t2_loaded_reg    <= t2_loaded_next;
            t2_count_reg     <= t2_count_next;
            acr_reg          <= acr_next;
            pcr_reg          <= pcr_next;
            ier_reg          <= ier_next;
            ifr_reg          <= ifr_next;
            t2_armed_reg     <= t2_armed_next;
        end
    end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the 6522 VIA register file unit.
// Needs via_pkg, via_stream_if and via_6522_register_file_unit from hdl/.
// Directed register accesses, then random bus traffic, checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    import via_pkg::*;

    // Command code the block must treat as a no-op
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned HOLD_AFTER   = 900;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    via_stream_if #(.data_t(req_t)) request ();
    via_stream_if #(.data_t(rsp_t)) result ();

    via_6522_register_file_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    // Directed stimulus row; hand-typed read byte and SR flag where obvious
    typedef struct {
        req_t       access;
        bit         typed;
        logic [7:0] read_byte;
        logic       sr_access;
    } directed_row_t;

    directed_row_t directed_plan[$];
    rsp_t          pending_results[$];

    // Predicted VIA register state
    logic [7:0]  orb, ora, ora_nh, ddrb, ddra;
    logic [15:0] t1_latch_q, t1_counter;
    logic [7:0]  t2_low_latch;
    logic [15:0] t2_reload, t2_counter;
    logic [7:0]  acr, pcr;
    logic [6:0]  ier;
    logic [7:0]  ifr;
    logic        t2_int_armed;

    // Run statistics
    int unsigned items_accepted;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned unexpected_count;
    int unsigned read_count, write_count, raise_count;
    int unsigned irq_seen, sr_seen;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void reset_via_state();
        orb = '0; ora = '0; ora_nh = '0;
        ddrb = DDRB_RESET; ddra = '0;
        t1_latch_q = '0; t1_counter = COUNT_RESET;
        t2_low_latch = '0; t2_reload = '0; t2_counter = COUNT_RESET;
        acr = '0; pcr = '0; ier = '0; ifr = '0; t2_int_armed = 1'b0;
    endfunction

    // Clear IFR bits, then recompute the summary bit
    function automatic void clear_ifr(input logic [7:0] mask);
        logic [7:0] f;
        f = ifr & ~mask & ~FLAG_ANY;
        if ((f[6:0] & ier) != '0)
            f = f | FLAG_ANY;
        ifr = f;
    endfunction

    // Set IFR bits; request an interrupt if any of them is enabled
    function automatic logic raise_ifr(input logic [6:0] flags);
        ifr = ifr | {1'b0, flags};
        if ((ier & flags) != '0)
        begin
            ifr = ifr | FLAG_ANY;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // CB2 is left alone when PCR selects independent interrupt mode
    function automatic void clear_port_b_flags();
        logic [7:0] m;
        m = FLAG_CB1;
        if (pcr[7:5] != PCR_IND_NEG && pcr[7:5] != PCR_IND_POS)
            m = m | FLAG_CB2;
        clear_ifr(m);
    endfunction

    function automatic void clear_port_a_flags();
        logic [7:0] m;
        m = FLAG_CA1;
        if (pcr[3:1] != PCR_IND_NEG && pcr[3:1] != PCR_IND_POS)
            m = m | FLAG_CA2;
        clear_ifr(m);
    endfunction

    function automatic logic [7:0] ddr_merge(input logic [7:0] prev, input logic [7:0] val,
                                             input logic [7:0] dir);
        return (prev & ~dir) | (val & dir);
    endfunction

    function automatic rsp_t predict_access(input req_t a);
        rsp_t r;
        r = '0;
        case (a.command)
            CMD_READ:
                case (a.address)
                    ADDR_ORB:
                    begin
                        clear_port_b_flags();
                        r.read_data = orb;
                    end
                    ADDR_ORA:
                    begin
                        clear_port_a_flags();
                        r.read_data = ora;
                    end
                    ADDR_DDRB:   r.read_data = ddrb;
                    ADDR_DDRA:   r.read_data = ddra;
                    ADDR_T1CL:
                    begin
                        clear_ifr(FLAG_T1);
                        r.read_data = t1_counter[7:0];
                    end
                    ADDR_T1CH:   r.read_data = t1_counter[15:8];
                    ADDR_T1LL:   r.read_data = t1_latch_q[7:0];
                    ADDR_T1LH:   r.read_data = t1_latch_q[15:8];
                    ADDR_T2CL:
                    begin
                        t2_int_armed = 1'b1;
                        r.read_data = t2_reload[7:0];
                    end
                    ADDR_T2CH:   r.read_data = t2_reload[15:8];
                    ADDR_SR:     r.unsupported_access = 1'b1;
                    ADDR_ACR:    r.read_data = acr;
                    ADDR_PCR:    r.read_data = pcr;
                    ADDR_IFR:    r.read_data = ifr;
                    ADDR_IER:    r.read_data = {1'b1, ier};
                    default:     r.read_data = ora_nh;
                endcase
            CMD_WRITE:
                case (a.address)
                    ADDR_ORB:
                    begin
                        orb = ddr_merge(orb, a.write_data, ddrb);
                        clear_port_b_flags();
                    end
                    ADDR_ORA:
                    begin
                        ora = ddr_merge(ora, a.write_data, ddra);
                        clear_port_a_flags();
                    end
                    ADDR_DDRB:   ddrb = a.write_data;
                    ADDR_DDRA:   ddra = a.write_data;
                    ADDR_T1CL,
                    ADDR_T1LL:   t1_latch_q[7:0] = a.write_data;
                    ADDR_T1LH:   t1_latch_q[15:8] = a.write_data;
                    ADDR_T1CH:
                    begin
                        // load counter, drop PB7 when it is an output
                        t1_latch_q[15:8] = a.write_data;
                        t1_counter = t1_latch_q;
                        clear_ifr(FLAG_T1);
                        orb = orb & ~(ddrb & FLAG_ANY);
                        clear_port_b_flags();
                    end
                    ADDR_T2CL:   t2_low_latch = a.write_data;
                    ADDR_T2CH:
                    begin
                        t2_reload = {a.write_data, t2_low_latch};
                        t2_counter = t2_reload;
                        t2_int_armed = 1'b1;
                        clear_ifr(FLAG_T2);
                    end
                    ADDR_SR:     r.unsupported_access = 1'b1;
                    ADDR_ACR:    acr = a.write_data;
                    ADDR_PCR:    pcr = a.write_data;
                    ADDR_IFR:    clear_ifr(a.write_data);
                    ADDR_IER:
                    begin
                        // bit 7 selects set or clear
                        if (a.write_data[7])
                            ier = ier | a.write_data[6:0];
                        else
                            ier = ier & ~a.write_data[6:0];
                        r.irq_pulse = raise_ifr(ifr[6:0]);
                    end
                    default:     ora_nh = ddr_merge(ora_nh, a.write_data, ddra);
                endcase
            CMD_RAISE:
                r.irq_pulse = raise_ifr(a.raise_flags);
            default: ;
        endcase
        r.port_b_value         = orb;
        r.port_a_value         = ora;
        r.timer1_value         = t1_counter;
        r.timer2_value         = t2_counter;
        r.timer2_irq_armed     = t2_int_armed;
        r.timer1_free_run      = acr[6];
        r.timer1_drives_pb7    = acr[7];
        r.timer2_counts_pulses = acr[5];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic void add_row(input logic [1:0] cmd, input logic [3:0] addr,
                                    input logic [7:0] wd, input logic [6:0] rf,
                                    input bit typed = 1'b0, input logic [7:0] rd = '0,
                                    input logic sr = 1'b0);
        directed_row_t row;
        row.access.command     = cmd;
        row.access.address     = addr;
        row.access.write_data  = wd;
        row.access.raise_flags = rf;
        row.typed              = typed;
        row.read_byte          = rd;
        row.sr_access          = sr;
        directed_plan.push_back(row);
    endfunction

    function automatic req_t random_access();
        req_t it;
        int unsigned pick;
        it = req_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.command = CMD_READ;
        else if (pick < 80)
            it.command = CMD_WRITE;
        else
            it.command = CMD_RAISE;
        it.address = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0)
            it.write_data = $urandom_range(0, 1) ? 8'hff : 8'h00;
        // PCR writes often pick the independent CA2/CB2 modes
        if (it.command == CMD_WRITE && it.address == ADDR_PCR && $urandom_range(0, 1))
        begin
            it.write_data[7:5] = $urandom_range(0, 1) ? PCR_IND_NEG : PCR_IND_POS;
            it.write_data[3:1] = $urandom_range(0, 1) ? PCR_IND_NEG : PCR_IND_POS;
        end
        if (it.command == CMD_RAISE && $urandom_range(0, 2) == 0)
            it.raise_flags = 7'(1 << $urandom_range(0, 6));
        return it;
    endfunction

    // Offer one item from a falling edge; log its expectation when taken
    task automatic offer(input req_t it, input bit typed, input logic [7:0] rd,
                         input logic sr);
        rsp_t exp;
        request.data  <= it;
        request.valid <= 1'b1;
        @(posedge clk);
        while (!(request.valid && request.ready))
            @(posedge clk);
        exp = predict_access(it);
        if (typed)
        begin
            exp.read_data          = rd;
            exp.unsupported_access = sr;
        end
        pending_results.push_back(exp);
        items_accepted++;
        case (it.command)
            CMD_READ:  read_count++;
            CMD_WRITE: write_count++;
            CMD_RAISE: raise_count++;
            default: ;
        endcase
        @(negedge clk);
    endtask

    int unsigned burst_left;

    // Sender pacing: bursts with random gaps, sometimes a long gap-free run
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(100, 200);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 30);
                gap = $urandom_range(0, 8);
            end
            if (gap != 0)
            begin
                request.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // ---------------------------------------------------------------
    // Receiver: shifting stall pattern plus one long hold-off
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned mode, mode_left, phase;
        bit          held;
        result.ready = 1'b0;
        mode = 0; mode_left = 0; phase = 0; held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && items_accepted >= HOLD_AFTER)
            begin
                held = 1'b1;
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                0:       result.ready <= 1'b1;
                1:       result.ready <= 1'($urandom_range(0, 1));
                2:       result.ready <= (phase % 4 == 0);
                default: result.ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic check_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                         $time, results_checked, field, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t got, exp;
        if (rst_n && result.valid && result.ready)
        begin
            got = result.data;
            if (pending_results.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= MAX_REPORTS)
                    $display("[%0t] result with no item outstanding: 0x%0h", $time, got);
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("read_data", 16'(exp.read_data), 16'(got.read_data));
                check_field("irq_pulse", 16'(exp.irq_pulse), 16'(got.irq_pulse));
                check_field("unsupported_access", 16'(exp.unsupported_access),
                            16'(got.unsupported_access));
                check_field("port_b_value", 16'(exp.port_b_value), 16'(got.port_b_value));
                check_field("port_a_value", 16'(exp.port_a_value), 16'(got.port_a_value));
                check_field("timer1_value", exp.timer1_value, got.timer1_value);
                check_field("timer2_value", exp.timer2_value, got.timer2_value);
                check_field("timer2_irq_armed", 16'(exp.timer2_irq_armed),
                            16'(got.timer2_irq_armed));
                check_field("timer1_free_run", 16'(exp.timer1_free_run),
                            16'(got.timer1_free_run));
                check_field("timer1_drives_pb7", 16'(exp.timer1_drives_pb7),
                            16'(got.timer1_drives_pb7));
                check_field("timer2_counts_pulses", 16'(exp.timer2_counts_pulses),
                            16'(got.timer2_counts_pulses));
                results_checked++;
                if (got.irq_pulse === 1'b1)
                    irq_seen++;
                if (got.unsupported_access === 1'b1)
                    sr_seen++;
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long
    initial
    begin
        int unsigned idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (request.valid && request.ready) || (result.valid && result.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 idle, pending_results.size());
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned waited;
        int unsigned leftover;
        rst_n          = 1'b0;
        request.valid  = 1'b0;
        request.data   = '0;
        items_accepted = 0; results_checked = 0;
        mismatch_count = 0; unexpected_count = 0;
        read_count = 0; write_count = 0; raise_count = 0;
        irq_seen = 0; sr_seen = 0;
        burst_left = 0;
        reset_via_state();

        // Reset values, SR, every port and timer register, IER/IFR, PCR modes
        add_row(CMD_READ,   ADDR_DDRB,  8'h00, 7'h00, 1'b1, 8'hff, 1'b0);
        add_row(CMD_READ,   ADDR_T1CH,  8'h00, 7'h00, 1'b1, 8'hff, 1'b0);
        add_row(CMD_READ,   ADDR_IER,   8'h00, 7'h00, 1'b1, 8'h80, 1'b0);
        add_row(CMD_READ,   ADDR_SR,    8'h00, 7'h00, 1'b1, 8'h00, 1'b1);
        add_row(CMD_WRITE,  ADDR_SR,    8'hff, 7'h7f, 1'b1, 8'h00, 1'b1);
        add_row(CMD_WRITE,  ADDR_DDRA,  8'hff, 7'h00);
        add_row(CMD_WRITE,  ADDR_ORA,   8'ha5, 7'h00);
        add_row(CMD_WRITE,  ADDR_ORB,   8'hff, 7'h00);
        add_row(CMD_WRITE,  ADDR_ORA_NH, 8'h5a, 7'h00);
        add_row(CMD_WRITE,  ADDR_T1LL,  8'h34, 7'h00);
        add_row(CMD_WRITE,  ADDR_T1CH,  8'h12, 7'h00);
        add_row(CMD_WRITE,  ADDR_T1CL,  8'hff, 7'h00);
        add_row(CMD_READ,   ADDR_T1CL,  8'h00, 7'h00);
        add_row(CMD_WRITE,  ADDR_T1LH,  8'h00, 7'h00);
        add_row(CMD_WRITE,  ADDR_T2CL,  8'hcd, 7'h00);
        add_row(CMD_WRITE,  ADDR_T2CH,  8'hab, 7'h00);
        add_row(CMD_READ,   ADDR_T2CL,  8'h00, 7'h00);
        add_row(CMD_WRITE,  ADDR_ACR,   8'he0, 7'h00);
        add_row(CMD_WRITE,  ADDR_IER,   8'hff, 7'h00);
        add_row(CMD_RAISE,  ADDR_ORB,   8'h00, 7'h7f);
        add_row(CMD_READ,   ADDR_IFR,   8'h00, 7'h00, 1'b1, 8'hff, 1'b0);
        add_row(CMD_WRITE,  ADDR_PCR,   8'h22, 7'h00);
        add_row(CMD_READ,   ADDR_ORB,   8'h00, 7'h00);
        add_row(CMD_WRITE,  ADDR_IFR,   8'h7f, 7'h00);
        add_row(CMD_WRITE,  ADDR_IER,   8'h7f, 7'h00);
        add_row(CMD_UNUSED, ADDR_DDRB,  8'hff, 7'h7f, 1'b1, 8'h00, 1'b0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        foreach (directed_plan[i])
        begin
            pace_sender();
            offer(directed_plan[i].access, directed_plan[i].typed,
                  directed_plan[i].read_byte, directed_plan[i].sr_access);
        end

        // Random part
        repeat (RANDOM_ITEMS)
        begin
            pace_sender();
            offer(random_access(), 1'b0, 8'h00, 1'b0);
        end
        request.valid <= 1'b0;

        // Drain, then wait on to catch stray results
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);

        leftover = pending_results.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);
        $display("Ran %0d bus items: %0d reads, %0d writes, %0d flag raises",
                 items_accepted, read_count, write_count, raise_count);
        $display("Checked %0d results (%0d IRQ requests, %0d SR accesses), %0d mismatches",
                 results_checked, irq_seen, sr_seen, mismatch_count + unexpected_count);
        if (mismatch_count == 0 && unexpected_count == 0 && leftover == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ via_6522_register_file_unit.f @@
hdl/via_pkg.sv
hdl/via_stream_if.sv
hdl/via_pipe_reg.sv
hdl/via_reg_core.sv
hdl/via_6522_register_file_unit.sv
dv/testbench.sv
